// ----- sv/sadf_pkg.sv -----
`default_nettype none
package sadf_pkg;

    // fixed field widths
    localparam int W_ADDR  = 64;
    localparam int W_SIZE  = 13;
    localparam int W_CNT   = 11;
    localparam int W_SLOT  = 10;
    localparam int W_REQ   = 2;
    localparam int W_FRAME = 2;
    localparam int W_STAT  = 3;
    localparam int W_CFGI  = 2;

    // request codes
    localparam logic [W_REQ-1:0] REQ_ALLOC = 2'd0;
    localparam logic [W_REQ-1:0] REQ_FREE  = 2'd1;
    localparam logic [W_REQ-1:0] REQ_PROC  = 2'd2;

    // result status codes
    localparam logic [W_STAT-1:0] ST_OK         = 3'd0;
    localparam logic [W_STAT-1:0] ST_NO_SLOT    = 3'd1;
    localparam logic [W_STAT-1:0] ST_INVALID    = 3'd2;
    localparam logic [W_STAT-1:0] ST_BAD_HANDLE = 3'd3;
    localparam logic [W_STAT-1:0] ST_BAD_FRAME  = 3'd4;

    // register indexes
    localparam logic [W_CFGI-1:0] CFG_BASE  = 2'd0;
    localparam logic [W_CFGI-1:0] CFG_SIZE  = 2'd1;
    localparam logic [W_CFGI-1:0] CFG_COUNT = 2'd2;

    // register reset values
    localparam logic [W_SIZE-1:0] SIZE_RST  = 13'd32;
    localparam logic [W_CNT-1:0]  COUNT_RST = 11'd1024;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_ALLOC_RD,
        S_ALLOC_ADD,
        S_FREE_CHK,
        S_PROC_RD,
        S_PROC_WR,
        S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic              capture;
        logic              alloc_mul;
        logic              alloc_fin;
        logic              free_mul;
        logic              free_fin;
        logic              proc_init;
        logic              proc_wr;
        logic              proc_fin;
        logic              set_res;
        logic [W_STAT-1:0] res_code;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [W_REQ-1:0] req;
        logic             alloc_full;
        logic             hvalid;
        logic             frame_bad;
        logic             proc_more;
    } t_stat;

endpackage
`default_nettype wire

// ----- sv/sadf_req_if.sv -----
`default_nettype none
interface sadf_req_if;
    import sadf_pkg::*;

    logic               valid;
    logic               ready;
    logic [W_REQ-1:0]   req_type;
    logic [W_FRAME-1:0] frame_index;
    logic               handle_valid;
    logic [W_ADDR-1:0]  handle_address;
    logic [W_SLOT-1:0]  handle_slot;

    modport source (output valid, req_type, frame_index, handle_valid, handle_address,
                    handle_slot, input ready);
    modport sink (input valid, req_type, frame_index, handle_valid, handle_address,
                  handle_slot, output ready);
endinterface
`default_nettype wire

// ----- sv/sadf_res_if.sv -----
`default_nettype none
interface sadf_res_if;
    import sadf_pkg::*;

    logic              valid;
    logic              ready;
    logic [W_STAT-1:0] status;
    logic [W_SLOT-1:0] slot_index;
    logic [W_ADDR-1:0] slot_address;
    logic [W_CNT-1:0]  returned_count;

    modport source (output valid, status, slot_index, slot_address, returned_count,
                    input ready);
    modport sink (input valid, status, slot_index, slot_address, returned_count,
                  output ready);
endinterface
`default_nettype wire

// ----- sv/sadf_ram.sv -----
`default_nettype none
module sadf_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ----- sv/sadf_ctrl.sv -----
`default_nettype none
module sadf_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    input  wire sadf_pkg::t_stat i_stat,
    output sadf_pkg::t_cmd       o_cmd
);
    import sadf_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                unique case (i_stat.req)
                    REQ_ALLOC: n_state = i_stat.alloc_full ? S_OUT : S_ALLOC_RD;
                    REQ_FREE: begin
                        n_state = (!i_stat.hvalid || i_stat.frame_bad) ? S_OUT : S_FREE_CHK;
                    end
                    REQ_PROC:  n_state = i_stat.frame_bad ? S_OUT : S_PROC_RD;
                    default:   n_state = S_OUT;
                endcase
            end
            S_ALLOC_RD:  n_state = S_ALLOC_ADD;
            S_ALLOC_ADD: n_state = S_OUT;
            S_FREE_CHK:  n_state = S_OUT;
            S_PROC_RD:   n_state = i_stat.proc_more ? S_PROC_WR : S_OUT;
            S_PROC_WR:   n_state = S_PROC_RD;
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default:     n_state = S_IDLE;
        endcase
    end

    // commands and handshakes
    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_EXEC: begin
                unique case (i_stat.req)
                    REQ_ALLOC: begin
                        if (i_stat.alloc_full) begin
                            o_cmd.set_res  = 1'b1;
                            o_cmd.res_code = ST_NO_SLOT;
                        end
                    end
                    REQ_FREE: begin
                        if (!i_stat.hvalid) begin
                            o_cmd.set_res  = 1'b1;
                            o_cmd.res_code = ST_INVALID;
                        end else if (i_stat.frame_bad) begin
                            o_cmd.set_res  = 1'b1;
                            o_cmd.res_code = ST_BAD_FRAME;
                        end else begin
                            o_cmd.free_mul = 1'b1;
                        end
                    end
                    REQ_PROC: begin
                        if (i_stat.frame_bad) begin
                            o_cmd.set_res  = 1'b1;
                            o_cmd.res_code = ST_BAD_FRAME;
                        end else begin
                            o_cmd.proc_init = 1'b1;
                        end
                    end
                    default: begin
                        o_cmd.set_res  = 1'b1;
                        o_cmd.res_code = ST_OK;
                    end
                endcase
            end
            S_ALLOC_RD:  o_cmd.alloc_mul = 1'b1;
            S_ALLOC_ADD: o_cmd.alloc_fin = 1'b1;
            S_FREE_CHK:  o_cmd.free_fin  = 1'b1;
            S_PROC_RD:   o_cmd.proc_fin  = !i_stat.proc_more;
            S_PROC_WR:   o_cmd.proc_wr   = 1'b1;
            S_OUT:       o_out_valid     = 1'b1;
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- sv/sadf_dp.sv -----
`default_nettype none
module sadf_dp #(
    parameter int CAPACITY   = 1024,
    parameter int NUM_FRAMES = 3
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [sadf_pkg::W_CFGI-1:0]       i_cfg_index,
    input  wire logic [sadf_pkg::W_ADDR-1:0]       i_cfg_data,
    input  wire logic [sadf_pkg::W_REQ-1:0]        i_req_type,
    input  wire logic [sadf_pkg::W_FRAME-1:0]      i_frame_index,
    input  wire logic                              i_handle_valid,
    input  wire logic [sadf_pkg::W_ADDR-1:0]       i_handle_address,
    input  wire logic [sadf_pkg::W_SLOT-1:0]       i_handle_slot,
    input  wire sadf_pkg::t_cmd                    i_cmd,
    output sadf_pkg::t_stat                        o_stat,
    output logic      [sadf_pkg::W_STAT-1:0]       o_status,
    output logic      [sadf_pkg::W_SLOT-1:0]       o_slot_index,
    output logic      [sadf_pkg::W_ADDR-1:0]       o_slot_address,
    output logic      [sadf_pkg::W_CNT-1:0]        o_returned_count
);
    import sadf_pkg::*;

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int SAW  = CAPACITY > 1 ? $clog2(CAPACITY) : 1;
    localparam int EW   = SAW > W_SLOT ? SAW : W_SLOT;
    localparam int PW   = EW + W_SIZE;
    localparam int DD   = NUM_FRAMES * CAPACITY;
    localparam int DAW  = DD > 1 ? $clog2(DD) : 1;
    localparam int FW   = NUM_FRAMES > 1 ? $clog2(NUM_FRAMES) : 1;
    localparam int LW   = CW > W_CNT ? CW : W_CNT;

    // configuration
    logic [W_ADDR-1:0]  r_base;
    logic [W_SIZE-1:0]  r_size;
    logic [W_CNT-1:0]   r_count;

    // captured item
    logic [W_REQ-1:0]   r_req;
    logic [W_FRAME-1:0] r_frame;
    logic               r_hvalid;
    logic [W_ADDR-1:0]  r_haddr;
    logic [W_SLOT-1:0]  r_hslot;

    // allocator state
    logic [CW-1:0]      r_used;
    logic [CW-1:0]      r_hw;
    logic [CW-1:0]      r_dcnt [NUM_FRAMES];
    logic [CW-1:0]      r_k;
    logic [CW-1:0]      r_n;
    logic [CW-1:0]      r_done;
    logic [EW-1:0]      r_idx;
    logic [PW-1:0]      r_prod;

    // result registers
    logic [W_STAT-1:0]  r_status;
    logic [W_SLOT-1:0]  r_slot;
    logic [W_ADDR-1:0]  r_addr;
    logic [W_CNT-1:0]   r_ret;

    logic [FW-1:0]      frame_sel;
    logic [CW-1:0]      cur_dcnt;
    logic [EW-1:0]      stk_rdata;
    logic [W_SLOT-1:0]  def_rdata;
    logic [EW-1:0]      idx_sel;
    logic [CW-1:0]      used_dec;
    logic [W_ADDR:0]    diff_full;
    logic               free_bad;
    logic [DAW-1:0]     def_base;
    logic               def_we;

    assign frame_sel = r_frame[FW-1:0];
    assign cur_dcnt  = r_dcnt[frame_sel];
    assign used_dec  = r_used - CW'(1);
    assign def_base  = DAW'(frame_sel) * DAW'(CAPACITY);

    // status back to the controller
    assign o_stat.req        = r_req;
    assign o_stat.hvalid     = r_hvalid;
    assign o_stat.frame_bad  = {1'b0, r_frame} >= 3'(NUM_FRAMES);
    assign o_stat.alloc_full = (LW'(r_used) >= LW'(r_count)) || (r_used >= CW'(CAPACITY));
    assign o_stat.proc_more  = (r_k < r_n) && (r_used != '0);

    // slots above the high-water mark were never written back and hold their own index
    assign idx_sel = (r_used >= r_hw) ? EW'(r_used) : stk_rdata;

    // handle check: one subtract gives the borrow and the offset
    assign diff_full = {1'b0, r_haddr} - {1'b0, r_base};
    assign free_bad  = (r_size == '0) || diff_full[W_ADDR]
                       || (diff_full[W_ADDR-1:0] != W_ADDR'(r_prod))
                       || (cur_dcnt >= CW'(CAPACITY));
    assign def_we    = i_cmd.free_fin && !free_bad;

    // free list memory
    sadf_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_stack (
        .i_clk   (i_clk),
        .i_we    (i_cmd.proc_wr),
        .i_waddr (used_dec[SAW-1:0]),
        .i_wdata (EW'(def_rdata)),
        .i_raddr (r_used[SAW-1:0]),
        .o_rdata (stk_rdata)
    );

    // deferred lists, one region per frame
    sadf_ram #(.WIDTH(W_SLOT), .DEPTH(DD)) u_deferred (
        .i_clk   (i_clk),
        .i_we    (def_we),
        .i_waddr (def_base + DAW'(cur_dcnt)),
        .i_wdata (r_hslot),
        .i_raddr (def_base + DAW'(r_k)),
        .o_rdata (def_rdata)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_size  <= SIZE_RST;
            r_count <= COUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BASE:  r_base  <= i_cfg_data;
                CFG_SIZE:  r_size  <= i_cfg_data[W_SIZE-1:0];
                CFG_COUNT: r_count <= i_cfg_data[W_CNT-1:0];
                default:   r_base  <= r_base;
            endcase
        end
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req    <= i_req_type;
            r_frame  <= i_frame_index;
            r_hvalid <= i_handle_valid;
            r_haddr  <= i_handle_address;
            r_hslot  <= i_handle_slot;
        end
    end

    // products for address and handle check
    always_ff @(posedge i_clk) begin
        if (i_cmd.alloc_mul) begin
            r_idx  <= idx_sel;
            r_prod <= PW'(idx_sel) * PW'(r_size);
        end else if (i_cmd.free_mul) begin
            r_prod <= PW'(r_hslot) * PW'(r_size);
        end
    end

    // stack pointer, high-water mark and deferred counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_hw   <= '0;
            for (int f = 0; f < NUM_FRAMES; f++) begin
                r_dcnt[f] <= '0;
            end
        end else begin
            if (i_cmd.alloc_fin) begin
                r_used <= r_used + CW'(1);
                if (r_used == r_hw) r_hw <= r_hw + CW'(1);
            end
            if (i_cmd.proc_wr) r_used <= used_dec;
            if (def_we) r_dcnt[frame_sel] <= cur_dcnt + CW'(1);
            if (i_cmd.proc_fin) r_dcnt[frame_sel] <= '0;
        end
    end

    // process walk counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.proc_init) begin
            r_n    <= cur_dcnt;
            r_k    <= '0;
            r_done <= '0;
        end else if (i_cmd.proc_wr) begin
            r_k    <= r_k + CW'(1);
            r_done <= r_done + CW'(1);
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_res) begin
            r_status <= i_cmd.res_code;
            r_slot   <= '0;
            r_addr   <= '0;
            r_ret    <= '0;
        end else if (i_cmd.alloc_fin) begin
            r_status <= ST_OK;
            r_slot   <= r_idx[W_SLOT-1:0];
            r_addr   <= r_base + W_ADDR'(r_prod);
            r_ret    <= '0;
        end else if (i_cmd.free_fin) begin
            r_status <= free_bad ? ST_BAD_HANDLE : ST_OK;
            r_slot   <= free_bad ? '0 : r_hslot;
            r_addr   <= '0;
            r_ret    <= '0;
        end else if (i_cmd.proc_fin) begin
            r_status <= ST_OK;
            r_slot   <= '0;
            r_addr   <= '0;
            r_ret    <= W_CNT'(r_done);
        end
    end

    assign o_status         = r_status;
    assign o_slot_index     = r_slot;
    assign o_slot_address   = r_addr;
    assign o_returned_count = r_ret;

endmodule
`default_nettype wire

// ----- sv/slot_allocator_frame_deferred_free.sv -----
// channel   dir   handshake      payload
// i_req     in    valid/ready    req_type, frame_index, handle_valid, handle_address, handle_slot
// o_res     out   valid/ready    status, slot_index, slot_address, returned_count
// cfg       in    i_cfg_we       i_cfg_index, i_cfg_data
//
// one item at a time: allocate reads the free list, then adds the address; free checks
// the handle; process reads the deferred list and writes the stack per slot written back;
// no free slot, invalid handle, bad frame and unused code skip to result, held until o_res.ready
// process pace is set by the registered read of the deferred list before each stack write
// reset clears the stack pointer, its high-water mark and the deferred counts at once;
// free list entries above the high-water mark read as their own index, so no clearing pass
`default_nettype none
module slot_allocator_frame_deferred_free #(
    parameter int CAPACITY   = 1024,
    parameter int NUM_FRAMES = 3
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [sadf_pkg::W_CFGI-1:0] i_cfg_index,
    input  wire logic [sadf_pkg::W_ADDR-1:0] i_cfg_data,
    sadf_req_if.sink                         i_req,
    sadf_res_if.source                       o_res
);
    import sadf_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequencing
    sadf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // storage and arithmetic
    sadf_dp #(.CAPACITY(CAPACITY), .NUM_FRAMES(NUM_FRAMES)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_req_type       (i_req.req_type),
        .i_frame_index    (i_req.frame_index),
        .i_handle_valid   (i_req.handle_valid),
        .i_handle_address (i_req.handle_address),
        .i_handle_slot    (i_req.handle_slot),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_status         (o_res.status),
        .o_slot_index     (o_res.slot_index),
        .o_slot_address   (o_res.slot_address),
        .o_returned_count (o_res.returned_count)
    );

endmodule
`default_nettype wire
